>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define SBS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define SBS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SBS_ASSERT_IMPL(name, ante, cons)
`define SBS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> rtl/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Widths, constants and shared types of the segment boundary splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

  localparam int unsigned OFF_W      = 31;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned SEG_W      = 25;
  localparam int unsigned WITHIN_W   = 24;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned CAP_W      = 31;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 25;

  // Slot field and count register widths are sized for this many segments
  localparam int unsigned MAX_SEGMENTS = 64;

  localparam logic [SEG_W-1:0] SEG_BYTES_MAX = 25'h100_0000;
  localparam logic [SEG_W-1:0] SEG_BYTES_RST = 25'd4096;
  localparam logic [CNT_W-1:0] SEG_COUNT_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } sbs_unit_stat_t;

endpackage

`default_nettype wire

>>> rtl/sbs_req_if.sv
// ----------------------------------------------------------------------------
// sbs_req_if
// Append request channel: start offset and length with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbs_req_if import sbs_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] start_offset;
  logic [LEN_W-1:0] length;

  modport source (output valid, output start_offset, output length, input ready);
  modport sink   (input valid, input start_offset, input length, output ready);

endinterface

`default_nettype wire

>>> rtl/sbs_chunk_if.sv
// ----------------------------------------------------------------------------
// sbs_chunk_if
// Write chunk channel: slot, offset, length, error and last with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbs_chunk_if import sbs_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [WITHIN_W-1:0] offset_in_segment;
  logic [SEG_W-1:0]    chunk_bytes;
  logic                error;
  logic                last;

  modport source (output valid, output slot, output offset_in_segment,
                  output chunk_bytes, output error, output last, input ready);
  modport sink   (input valid, input slot, input offset_in_segment,
                  input chunk_bytes, input error, input last, output ready);

endinterface

`default_nettype wire

>>> rtl/sbs_serial_div.sv
// ----------------------------------------------------------------------------
// sbs_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, OFF_W quotient bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbs_serial_div import sbs_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire [OFF_W-1:0]      dividend,
  input  wire [SEG_W-1:0]      divisor,
  output sbs_unit_stat_t       stat,
  output logic [OFF_W-1:0]     quotient,
  output logic [WITHIN_W-1:0]  remainder
);

  localparam int unsigned          STEP_W    = $clog2(OFF_W);
  localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(OFF_W - 1);

  logic                busy_r, done_r;
  logic [STEP_W-1:0]   step_r;
  logic [OFF_W-1:0]    dvd_r, dvd_nxt;
  logic [SEG_W-1:0]    dvs_r;
  logic [WITHIN_W-1:0] rem_r, rem_nxt;
  logic [SEG_W-1:0]    trial;
  logic [SEG_W-1:0]    diff;
  logic                ge;

  // Shift the next dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    trial   = {rem_r, dvd_r[OFF_W-1]};
    ge      = (trial >= dvs_r);
    diff    = trial - dvs_r;
    rem_nxt = ge ? diff[WITHIN_W-1:0] : trial[WITHIN_W-1:0];
    dvd_nxt = {dvd_r[OFF_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (step_r == LAST_STEP)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> rtl/sbs_serial_mul.sv
// ----------------------------------------------------------------------------
// sbs_serial_mul
// Shift-add multiplier for the journal capacity: one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbs_serial_mul import sbs_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire [SEG_W-1:0]   mcand,
  input  wire [CNT_W-1:0]   mplier,
  output sbs_unit_stat_t    stat,
  output logic [CAP_W-1:0]  product
);

  localparam int unsigned       STEP_W    = $clog2(CNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

  logic               busy_r, done_r;
  logic [STEP_W-1:0]  step_r;
  logic [CAP_W-1:0]   mcand_r;
  logic [CNT_W-1:0]   mplier_r;
  logic [CAP_W-1:0]   acc_r, acc_nxt;

  // Add the shifted multiplicand where the current multiplier bit is set
  assign acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (step_r == LAST_STEP)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= {{(CAP_W - SEG_W){1'b0}}, mcand};
      mplier_r <= mplier;
      acc_r    <= '0;
      step_r   <= '0;
    end else if (busy_r) begin
      mcand_r  <= {mcand_r[CAP_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[CNT_W-1:1]};
      acc_r    <= acc_nxt;
      step_r   <= step_r + 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

`default_nettype wire

>>> rtl/segment_boundary_splitter_top.sv
// ----------------------------------------------------------------------------
// segment_boundary_splitter_top
// Splits journal append requests into per-segment write chunks.
// ----------------------------------------------------------------------------
// Usage:
//   in_req    : append request (start_offset, length), valid/ready transfer.
//   out_chunk : write chunks (slot, offset_in_segment, chunk_bytes, error,
//               last), valid/ready transfer, one per segment touched, in
//               ascending order; a rejected request gives one error chunk.
//   cfg_*     : register writes (segment size, segment count), taken at any
//               edge with cfg_we high; write only while the block is idle.
// Timing:
//   A bit-serial divider finds slot and in-segment offset while a shift-add
//   multiplier forms the capacity alongside. Once both are done the sequencer
//   decides, then chunks leave one per cycle while the output register is
//   free, 1 to 64 per request. in_req.ready stays low from the request
//   transfer until the final chunk is loaded, so requests do not overlap.
// Reset:
//   Registers return to 4096 bytes and 64 segments, the sequencer goes idle
//   and the output register empties.
// Stall:
//   A chunk waits in the output register until taken; generation of the
//   next chunk holds meanwhile. A new request is taken while the final chunk
//   of the previous one still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module segment_boundary_splitter_top import sbs_pkg::*; (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  sbs_req_if.sink               in_req,
  sbs_chunk_if.source           out_chunk
);

  // Clamp to MAX_SEGMENTS, or to the count register's own maximum if that is smaller
  localparam int unsigned CNT_LIMIT =
    (MAX_SEGMENTS < (2**CNT_W - 1)) ? MAX_SEGMENTS : (2**CNT_W - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } sbs_state_t;

  // Configuration
  logic [SEG_W-1:0] seg_bytes_r;
  logic [CNT_W-1:0] seg_count_r;
  logic [SEG_W-1:0] seg_eff;
  logic [CNT_W-1:0] cnt_eff;

  // Sequencer and request context
  sbs_state_t          state_r, state_nxt;
  logic                err_r;
  logic [CNT_W-1:0]    slot_r;
  logic [WITHIN_W-1:0] within_r;
  logic [LEN_W-1:0]    len_r;
  logic [OFF_W-1:0]    off_r;

  // Arithmetic units
  sbs_unit_stat_t      div_stat, mul_stat;
  logic [OFF_W-1:0]    quotient;
  logic [WITHIN_W-1:0] remainder;
  logic [CAP_W-1:0]    capacity;

  // Chunk datapath
  logic                in_acc;
  logic                out_free;
  logic                load_out;
  logic                calc_done;
  logic [SEG_W-1:0]    room;
  logic [SEG_W-1:0]    bytes;
  logic [LEN_W-1:0]    len_left;
  logic [SUM_W-1:0]    end_sum;
  logic                err_now;

  // Output register
  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [WITHIN_W-1:0] out_within_r;
  logic [SEG_W-1:0]    out_bytes_r;
  logic                out_error_r;
  logic                out_last_r;

  // --------------------------------------------------------------------------
  // Configuration registers, clamped on use
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_bytes_r <= SEG_BYTES_RST;
      seg_count_r <= SEG_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEG_BYTES: seg_bytes_r <= cfg_wdata[SEG_W-1:0];
        CFG_SEG_COUNT: seg_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign seg_eff = (seg_bytes_r > SEG_BYTES_MAX) ? SEG_BYTES_MAX : seg_bytes_r;
  assign cnt_eff = (seg_count_r > CNT_W'(CNT_LIMIT)) ? CNT_W'(CNT_LIMIT) : seg_count_r;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_acc       = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign out_free     = !out_valid_r || out_chunk.ready;
  assign calc_done    = div_stat.done && mul_stat.done;

  // --------------------------------------------------------------------------
  // Slot and offset by serial division, capacity by serial multiplication
  // --------------------------------------------------------------------------
  sbs_serial_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .dividend  (in_req.start_offset),
    .divisor   (seg_eff),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  sbs_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .mcand   (seg_eff),
    .mplier  (cnt_eff),
    .stat    (mul_stat),
    .product (capacity)
  );

  // --------------------------------------------------------------------------
  // Rejection test and chunk sizing
  // --------------------------------------------------------------------------
  always_comb begin
    // Request end must not pass capacity; an empty request or a zero-size
    // segment is rejected outright
    end_sum = {1'b0, off_r} + {1'b0, len_r};
    err_now = (seg_eff == '0) || (len_r == '0) ||
              (end_sum > {{(SUM_W - CAP_W){1'b0}}, capacity});

    // Chunk runs to the end of the segment or the end of the request
    room     = seg_eff - {1'b0, within_r};
    bytes    = (len_r < {{(LEN_W - SEG_W){1'b0}}, room}) ? len_r[SEG_W-1:0] : room;
    len_left = len_r - {{(LEN_W - SEG_W){1'b0}}, bytes};
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CALC;
      end
      S_CALC: begin
        if (calc_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (err_r || (len_left == '0)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request context: capture on transfer, seed from the divider, advance per chunk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      off_r <= in_req.start_offset;
      len_r <= in_req.length;
    end else if ((state_r == S_CALC) && calc_done) begin
      err_r    <= err_now;
      slot_r   <= quotient[CNT_W-1:0];
      within_r <= remainder;
    end else if (load_out && !err_r) begin
      slot_r   <= slot_r + 1'b1;
      within_r <= '0;
      len_r    <= len_left;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chunk.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (err_r) begin
        out_slot_r   <= '0;
        out_within_r <= '0;
        out_bytes_r  <= '0;
        out_error_r  <= 1'b1;
        out_last_r   <= 1'b1;
      end else begin
        out_slot_r   <= slot_r[SLOT_W-1:0];
        out_within_r <= within_r;
        out_bytes_r  <= bytes;
        out_error_r  <= 1'b0;
        out_last_r   <= (len_left == '0);
      end
    end
  end

  assign out_chunk.valid             = out_valid_r;
  assign out_chunk.slot              = out_slot_r;
  assign out_chunk.offset_in_segment = out_within_r;
  assign out_chunk.chunk_bytes       = out_bytes_r;
  assign out_chunk.error             = out_error_r;
  assign out_chunk.last              = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SBS_ASSERT_NEXT(a_accept_to_calc, in_acc, state_r == S_CALC)
  `SBS_ASSERT_IMPL(a_units_quiet_idle, state_r == S_IDLE, !div_stat.busy && !mul_stat.busy)
  `SBS_ASSERT_IMPL(a_error_is_last, out_valid_r && out_error_r, out_last_r && (out_bytes_r == '0))
  `SBS_ASSERT_IMPL(a_chunk_nonempty, out_valid_r && !out_error_r, out_bytes_r != '0)

endmodule

`default_nettype wire
